@@ rtl/tpi_pkg.sv @@
package tpi_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int COORD_BITS    = 24;
    localparam int TIME_W        = 32;
    localparam int HEAD_W        = 16;
    localparam int LIMIT_W       = 16;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

    // heading difference before and after the short-way fold
    localparam int DH_W   = HEAD_W + 2;
    localparam int MAG_W  = (COORD_BITS + 1 > DH_W) ? COORD_BITS + 1 : DH_W;
    localparam int PROD_W = MAG_W + TIME_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int LIMIT_RESET    = 200;
    localparam int HALF_TURN      = 180 * 128;
    localparam int FULL_TURN      = 360 * 128;
    localparam int NEG_HALF_TURN  = -180 * 128;

    typedef struct packed {
        logic signed [HEAD_W-1:0]     heading;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
        logic signed [TIME_W-1:0]     stime;
    } t_sample;

    localparam int SAMPLE_W = TIME_W + 2 * COORD_BITS + HEAD_W;
    localparam int RESULT_W = 2 * COORD_BITS + HEAD_W;

endpackage

@@ rtl/timed_position_interpolator.sv @@
// Add item: the sample is written on the accepting edge.
// Query item: the search walks back up to depth - 2 samples; one shared
// multiply-divide unit serves x, y and heading in turn, the ring memory gives
// one read a cycle. No new item is taken while a query is in progress.
// Empty store: a not-found result; single/early sample: the oldest sample; the
// next item is taken the cycle after the result is registered. Sync active-low reset empties the store.
module timed_position_interpolator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tpi_pkg::SAMPLE_W-1:0]  i_s_tdata,  // sample_time, x_in, y_in, heading_in
    input  logic                          i_s_tuser,  // kind
    // stream out
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tpi_pkg::RESULT_W-1:0]  o_m_tdata,  // x_out, y_out, heading_out
    output logic                          o_m_tuser,  // found
    // configuration
    input  logic                          i_cfg_we,
    input  logic [tpi_pkg::LIMIT_W-1:0]   i_cfg_data  // extrapolation_limit
);
    import tpi_pkg::*;

    localparam logic [1:0] CH_X = 2'd0;
    localparam logic [1:0] CH_Y = 2'd1;
    localparam logic [1:0] CH_H = 2'd2;

    localparam logic signed [SUM_W-1:0] C_MAX =
        {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_MIN = ~C_MAX;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_FIRST_D,
        S_SINGLE,
        S_SRCH,
        S_SRCH_D,
        S_RDB,
        S_RDB_D,
        S_SETUP,
        S_MD_START,
        S_MD_WAIT,
        S_OUT
    } t_state;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] k);
        logic [ADDR_W:0] s;
        s = {1'b0, base} + {1'b0, k};
        if (s >= (ADDR_W + 1)'(HISTORY_DEPTH)) begin
            s = s - (ADDR_W + 1)'(HISTORY_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > C_MAX) c = C_MAX;
        if (c < C_MIN) c = C_MIN;
        return c[COORD_BITS-1:0];
    endfunction

    // wrap once into [-180, 180), then saturate what is left outside
    function automatic logic signed [HEAD_W-1:0] wrap_heading(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] h;
        h = v;
        if (h >= HALF_TURN) begin
            h = h - SUM_W'(FULL_TURN);
        end else if (h < NEG_HALF_TURN) begin
            h = h + SUM_W'(FULL_TURN);
        end
        if (h < NEG_HALF_TURN) h = SUM_W'(NEG_HALF_TURN);
        if (h > HALF_TURN - 1) h = SUM_W'(HALF_TURN - 1);
        return h[HEAD_W-1:0];
    endfunction

    t_state                       r_state;
    logic [CNT_W-1:0]             r_count;
    logic [ADDR_W-1:0]            r_oldest;
    logic signed [TIME_W-1:0]     r_newest;
    logic [LIMIT_W-1:0]           r_limit;

    logic signed [TIME_W-1:0]     r_t;
    t_sample                      r_a;
    t_sample                      r_b;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_extrap;
    logic [1:0]                   r_chan;
    logic                         r_neg;
    logic [TIME_W-1:0]            r_num;
    logic [TIME_W-1:0]            r_den;

    logic                         r_res_found;
    logic signed [COORD_BITS-1:0] r_res_x;
    logic signed [COORD_BITS-1:0] r_res_y;
    logic signed [HEAD_W-1:0]     r_res_h;

    logic                         r_m_valid;
    logic [RESULT_W-1:0]          r_m_data;
    logic                         r_m_user;

    t_sample                      w_in;
    t_sample                      w_rd;
    logic [SAMPLE_W-1:0]          w_rd_raw;
    logic                         w_acc;
    logic                         w_we;
    logic                         w_full;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr;

    logic signed [COORD_BITS:0]   w_dx;
    logic signed [COORD_BITS:0]   w_dy;
    logic signed [DH_W-1:0]       w_dh_raw;
    logic signed [DH_W-1:0]       w_dh;
    logic signed [MAG_W:0]        w_delta;
    logic [MAG_W:0]               w_neg_delta;
    logic [MAG_W-1:0]             w_mag;
    t_sample                      w_base_s;
    logic signed [SUM_W-1:0]      w_base;
    logic signed [SUM_W-1:0]      w_qz;
    logic signed [SUM_W-1:0]      w_sum;

    logic signed [TIME_W:0]       w_dt_a;
    logic signed [TIME_W:0]       w_dt_b;
    logic signed [TIME_W:0]       w_span;

    logic                         w_md_start;
    logic                         w_md_done;
    logic [PROD_W-1:0]            w_quot;

    assign w_in       = t_sample'(i_s_tdata);
    assign w_rd       = t_sample'(w_rd_raw);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // add: keep only a strictly later sample; overwrite the oldest when full
    assign w_full  = (r_count == CNT_W'(HISTORY_DEPTH));
    assign w_we    = w_acc && !i_s_tuser && ((r_count == '0) || (r_newest < w_in.stime));
    assign w_waddr = w_full ? r_oldest : slot_of(r_oldest, r_count[ADDR_W-1:0]);

    always_comb begin
        case (r_state)
            S_FIRST: w_raddr = r_oldest;
            S_SRCH:  w_raddr = slot_of(r_oldest, r_idx[ADDR_W-1:0]);
            S_RDB:   w_raddr = slot_of(r_oldest, r_idx[ADDR_W-1:0]);
            default: w_raddr = r_oldest;
        endcase
    end

    tpi_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_raw)
    );

    // differences between the bracketing pair (a older, b newer)
    assign w_dx     = {r_b.x[COORD_BITS-1], r_b.x} - {r_a.x[COORD_BITS-1], r_a.x};
    assign w_dy     = {r_b.y[COORD_BITS-1], r_b.y} - {r_a.y[COORD_BITS-1], r_a.y};
    assign w_dh_raw = DH_W'(r_b.heading) - DH_W'(r_a.heading);

    // interpolation takes the heading the short way around
    always_comb begin
        w_dh = w_dh_raw;
        if (!r_extrap) begin
            if (w_dh_raw >= HALF_TURN) begin
                w_dh = w_dh_raw - DH_W'(FULL_TURN);
            end else if (w_dh_raw <= NEG_HALF_TURN) begin
                w_dh = w_dh_raw + DH_W'(FULL_TURN);
            end
        end
    end

    assign w_base_s = r_extrap ? r_b : r_a;

    always_comb begin
        case (r_chan)
            CH_X: begin
                w_delta = (MAG_W + 1)'(w_dx);
                w_base  = SUM_W'(w_base_s.x);
            end
            CH_Y: begin
                w_delta = (MAG_W + 1)'(w_dy);
                w_base  = SUM_W'(w_base_s.y);
            end
            default: begin
                w_delta = (MAG_W + 1)'(w_dh);
                w_base  = SUM_W'(w_base_s.heading);
            end
        endcase
    end

    assign w_neg_delta = -w_delta;
    assign w_mag       = w_delta[MAG_W] ? w_neg_delta[MAG_W-1:0] : w_delta[MAG_W-1:0];
    assign w_qz        = signed'({2'b00, w_quot});
    assign w_sum       = r_neg ? (w_base - w_qz) : (w_base + w_qz);

    assign w_dt_a = {r_t[TIME_W-1], r_t} - {r_a.stime[TIME_W-1], r_a.stime};
    assign w_dt_b = {r_t[TIME_W-1], r_t} - {r_b.stime[TIME_W-1], r_b.stime};
    assign w_span = {r_b.stime[TIME_W-1], r_b.stime} - {r_a.stime[TIME_W-1], r_a.stime};

    assign w_md_start = (r_state == S_MD_START);

    tpi_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_mag   (w_mag),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_md_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_oldest  <= '0;
            r_limit   <= LIMIT_W'(LIMIT_RESET);
            r_m_valid <= 1'b0;
            r_extrap  <= 1'b0;
            r_chan    <= CH_X;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end

            // store bookkeeping on an accepted add
            if (w_we) begin
                r_newest <= w_in.stime;
                if (w_full) begin
                    r_oldest <= (r_oldest == ADDR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : r_oldest + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end

            // load the result when the output is free; drop the shown result once taken
            if (r_state == S_OUT && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
                r_m_user  <= r_res_found;
                r_m_data  <= {r_res_h, r_res_y, r_res_x};
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_extrap <= 1'b0;
                    if (w_acc && i_s_tuser) begin
                        r_t <= w_in.stime;
                        if (r_count == '0) begin
                            r_res_found <= 1'b0;
                            r_res_x     <= '0;
                            r_res_y     <= '0;
                            r_res_h     <= '0;
                            r_state     <= S_OUT;
                        end else begin
                            r_res_found <= 1'b1;
                            r_state     <= S_FIRST;
                        end
                    end
                end
                S_FIRST: r_state <= S_FIRST_D;
                S_FIRST_D: begin
                    r_a   <= w_rd;
                    r_idx <= r_count - CNT_W'(2);
                    if (r_count == CNT_W'(1) || r_t < w_rd.stime) begin
                        r_state <= S_SINGLE;
                    end else begin
                        // at or past the newest sample: extrapolate from the last two
                        r_extrap <= !(r_t < r_newest);
                        r_state  <= S_SRCH;
                    end
                end
                S_SINGLE: begin
                    r_res_x <= r_a.x;
                    r_res_y <= r_a.y;
                    r_res_h <= wrap_heading(SUM_W'(r_a.heading));
                    r_state <= S_OUT;
                end
                S_SRCH: r_state <= S_SRCH_D;
                S_SRCH_D: begin
                    // walk back until the older entry is not later than the query
                    if (!r_extrap && r_idx != '0 && w_rd.stime > r_t) begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SRCH;
                    end else begin
                        r_a     <= w_rd;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RDB;
                    end
                end
                S_RDB: r_state <= S_RDB_D;
                S_RDB_D: begin
                    r_b     <= w_rd;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_den <= w_span[TIME_W-1:0];
                    if (r_extrap) begin
                        r_num <= (w_dt_b[TIME_W-1:0] > TIME_W'(r_limit)) ? TIME_W'(r_limit)
                                                                        : w_dt_b[TIME_W-1:0];
                    end else begin
                        r_num <= w_dt_a[TIME_W-1:0];
                    end
                    r_chan  <= CH_X;
                    r_state <= S_MD_START;
                end
                S_MD_START: begin
                    r_neg   <= w_delta[MAG_W];
                    r_state <= S_MD_WAIT;
                end
                S_MD_WAIT: begin
                    if (w_md_done) begin
                        case (r_chan)
                            CH_X:    r_res_x <= clamp_coord(w_sum);
                            CH_Y:    r_res_y <= clamp_coord(w_sum);
                            default: r_res_h <= wrap_heading(w_sum);
                        endcase
                        if (r_chan == CH_H) begin
                            r_state <= S_OUT;
                        end else begin
                            r_chan  <= r_chan + 1'b1;
                            r_state <= S_MD_START;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

@@ rtl/tpi_ram.sv @@
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/tpi_muldiv.sv @@
module tpi_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tpi_pkg::MAG_W-1:0]   i_mag,
    input  logic [tpi_pkg::TIME_W-1:0]  i_num,
    input  logic [tpi_pkg::TIME_W-1:0]  i_den,
    output logic                        o_done,
    output logic [tpi_pkg::PROD_W-1:0]  o_quot
);
    import tpi_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [PROD_W-1:0]   r_prod;
    logic [TIME_W-1:0]   r_rem;
    logic [TIME_W-1:0]   r_den;

    logic [TIME_W:0]     w_shift;
    logic [TIME_W:0]     w_diff;
    logic                w_ge;

    // one restoring step: bring down the next product bit
    assign w_shift = {r_rem, r_prod[PROD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign o_quot  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_prod  <= PROD_W'(i_mag) * PROD_W'(i_num);
                        r_rem   <= '0;
                        r_den   <= i_den;
                        r_step  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem  <= w_ge ? w_diff[TIME_W-1:0] : w_shift[TIME_W-1:0];
                    r_prod <= {r_prod[PROD_W-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(PROD_W - 1)) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpi_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  LONG_HOLD   = 3000;
    localparam int  DRAIN_WAIT  = 400;
    localparam bit  KIND_ADD    = 1'b0;
    localparam bit  KIND_QUERY  = 1'b1;
    localparam longint COORD_TOP = 64'sd1 <<< (COORD_BITS - 1);
    localparam longint QUOT_CAP  = 64'sd1 <<< 52;
    localparam longint TIME_MAX  = 64'sd2147483647;
    localparam longint TIME_MIN  = -64'sd2147483648;

    typedef struct {
        bit      kind;
        t_sample smp;
    } t_item;

    typedef struct {
        bit     found;
        longint x;
        longint y;
        longint heading;
    } t_position;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [SAMPLE_W-1:0]   i_s_tdata = '0;  // sample_time, x_in, y_in, heading_in
    logic                  i_s_tuser = 1'b0; // kind
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [RESULT_W-1:0]   o_m_tdata;       // x_out, y_out, heading_out
    logic                  o_m_tuser;       // found
    logic                  i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]    i_cfg_data = '0;  // extrapolation_limit

    timed_position_interpolator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the sample ring and the horizon register
    longint ring_time [HISTORY_DEPTH];
    longint ring_x    [HISTORY_DEPTH];
    longint ring_y    [HISTORY_DEPTH];
    longint ring_head [HISTORY_DEPTH];
    int     ring_count  = 0;
    int     ring_oldest = 0;
    longint horizon     = LIMIT_RESET;

    t_item     pending_items[$];
    t_position expected_positions[$];

    int  errors = 0;
    int  cycles = 0;
    int  adds_sent = 0;
    int  queries_sent = 0;
    int  positions_checked = 0;
    bit  sender_idles = 1'b0;
    bit  receiver_idles = 1'b0;
    int  hold_requests = 0;
    int  holds_done = 0;

    // Generator view of the accepted sample times
    longint gen_times[$];
    longint gen_newest = 0;

    function automatic int ring_slot(int k);
        return (ring_oldest + k) % HISTORY_DEPTH;
    endfunction

    // delta * n / d, magnitude truncated toward zero and capped at QUOT_CAP
    function automatic longint scale_delta(longint delta, longint n, longint d);
        longint mag;
        longint q;
        mag = (delta < 0) ? -delta : delta;
        q = (mag * n) / d;
        if (q > QUOT_CAP)
            q = QUOT_CAP;
        return (delta < 0) ? -q : q;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v < -COORD_TOP)
            return -COORD_TOP;
        if (v > COORD_TOP - 1)
            return COORD_TOP - 1;
        return v;
    endfunction

    function automatic longint wrap_head(longint h);
        if (h >= HALF_TURN)
            h -= FULL_TURN;
        else if (h < NEG_HALF_TURN)
            h += FULL_TURN;
        if (h < NEG_HALF_TURN)
            return NEG_HALF_TURN;
        if (h > HALF_TURN - 1)
            return HALF_TURN - 1;
        return h;
    endfunction

    // Update the shadow ring for an accepted item; queue the position a query yields
    task automatic predict_position(t_item it);
        longint    t;
        longint    n;
        longint    d;
        longint    dh;
        int        s;
        int        i;
        int        a;
        int        b;
        int        first;
        int        last;
        t_position pos;
        t = it.smp.stime;
        if (it.kind == KIND_ADD) begin
            if (ring_count != 0 && !(ring_time[ring_slot(ring_count - 1)] < t))
                return;
            if (ring_count < HISTORY_DEPTH) begin
                s = ring_slot(ring_count);
                ring_count++;
            end else begin
                s = ring_oldest;
                ring_oldest = (ring_oldest + 1) % HISTORY_DEPTH;
            end
            ring_time[s] = t;
            ring_x[s]    = it.smp.x;
            ring_y[s]    = it.smp.y;
            ring_head[s] = it.smp.heading;
            return;
        end
        pos = '{1'b0, 0, 0, 0};
        if (ring_count != 0) begin
            pos.found = 1'b1;
            first = ring_slot(0);
            last  = ring_slot(ring_count - 1);
            if (ring_count == 1 || t < ring_time[first]) begin
                pos.x = ring_x[first];
                pos.y = ring_y[first];
                pos.heading = wrap_head(ring_head[first]);
            end else if (t < ring_time[last]) begin
                // walk back to the bracketing pair
                i = ring_count - 2;
                while (i > 0 && ring_time[ring_slot(i)] > t)
                    i--;
                a = ring_slot(i);
                b = ring_slot(i + 1);
                n = t - ring_time[a];
                d = ring_time[b] - ring_time[a];
                dh = ring_head[b] - ring_head[a];
                if (dh >= HALF_TURN)
                    dh -= FULL_TURN;
                else if (dh <= NEG_HALF_TURN)
                    dh += FULL_TURN;
                pos.x = sat_coord(ring_x[a] + scale_delta(ring_x[b] - ring_x[a], n, d));
                pos.y = sat_coord(ring_y[a] + scale_delta(ring_y[b] - ring_y[a], n, d));
                pos.heading = wrap_head(ring_head[a] + scale_delta(dh, n, d));
            end else begin
                // extrapolate from the last two, raw heading difference
                a = ring_slot(ring_count - 2);
                n = t - ring_time[last];
                d = ring_time[last] - ring_time[a];
                if (n > horizon)
                    n = horizon;
                pos.x = sat_coord(ring_x[last] + scale_delta(ring_x[last] - ring_x[a], n, d));
                pos.y = sat_coord(ring_y[last] + scale_delta(ring_y[last] - ring_y[a], n, d));
                pos.heading = wrap_head(ring_head[last] +
                                        scale_delta(ring_head[last] - ring_head[a], n, d));
            end
        end
        expected_positions.insert(expected_positions.size(), pos);
    endtask

    // Sender: present queued items, hold each until taken, idle a random gap between items when sender_idles is set
    int    send_gap = 0;
    t_item on_bus;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (!i_s_tvalid || o_s_tready) begin
                if (i_s_tvalid) begin
                    predict_position(on_bus);
                    send_gap = sender_idles ? $urandom_range(0, 13) : 0;
                end
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    on_bus = pending_items.pop_front();
                    i_s_tdata  <= on_bus.smp;
                    i_s_tuser  <= on_bus.kind;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken item against the oldest expected position
    int        recv_gap = 0;
    int        hold_left = 0;
    t_position want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                positions_checked++;
                if (expected_positions.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item found=%0b data=%h", $realtime,
                             o_m_tuser, o_m_tdata);
                end else begin
                    want = expected_positions.pop_front();
                    if (o_m_tuser !== want.found ||
                        $signed(o_m_tdata[COORD_BITS-1:0]) !== want.x ||
                        $signed(o_m_tdata[2*COORD_BITS-1:COORD_BITS]) !== want.y ||
                        $signed(o_m_tdata[RESULT_W-1:2*COORD_BITS]) !== want.heading) begin
                        errors++;
                        $display("%0t: mismatch expected found=%0b x=%0d y=%0d h=%0d",
                                 $realtime, want.found, want.x, want.y, want.heading);
                        $display("%0t:          actual   found=%0b x=%0d y=%0d h=%0d",
                                 $realtime, o_m_tuser,
                                 $signed(o_m_tdata[COORD_BITS-1:0]),
                                 $signed(o_m_tdata[2*COORD_BITS-1:COORD_BITS]),
                                 $signed(o_m_tdata[RESULT_W-1:2*COORD_BITS]));
                    end
                end
                recv_gap = receiver_idles ? $urandom_range(0, 13) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (holds_done < hold_requests) begin
                // back-pressure long enough for the input side to stall
                holds_done++;
                hold_left = LONG_HOLD;
                i_m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic push_add(longint t, longint x, longint y, longint h);
        t_item it;
        it.kind = KIND_ADD;
        it.smp.stime = TIME_W'(t);
        it.smp.x = COORD_BITS'(x);
        it.smp.y = COORD_BITS'(y);
        it.smp.heading = HEAD_W'(h);
        pending_items.insert(pending_items.size(), it);
        adds_sent++;
        if (gen_times.size() == 0 || t > gen_newest) begin
            gen_newest = t;
            gen_times.insert(gen_times.size(), t);
            if (gen_times.size() > HISTORY_DEPTH)
                void'(gen_times.pop_front());
        end
    endtask

    // Queries carry random coordinates too; the block must ignore them
    task automatic push_query(longint t);
        t_item it;
        it.kind = KIND_QUERY;
        it.smp.stime = TIME_W'(t);
        it.smp.x = COORD_BITS'($urandom);
        it.smp.y = COORD_BITS'($urandom);
        it.smp.heading = HEAD_W'($urandom);
        pending_items.insert(pending_items.size(), it);
        queries_sent++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_s_tvalid || expected_positions.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_horizon(longint value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= LIMIT_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        horizon = value;
    endtask

    function automatic longint rand_coord(longint near);
        if ($urandom_range(0, 9) < 7)
            return sat_coord(near + $signed($urandom_range(0, 8192)) - 4096);
        return $signed($urandom_range(0, 2 * COORD_TOP - 1)) - COORD_TOP;
    endfunction

    function automatic longint rand_head();
        if ($urandom_range(0, 9) == 0)
            return $signed($urandom_range(0, 65535)) - 32768;
        return $signed($urandom_range(0, FULL_TURN - 1)) + NEG_HALF_TURN;
    endfunction

    // Mostly well-formed tracks: rising times, queries around the stored span
    task automatic random_items(int count);
        longint x;
        longint y;
        longint t;
        longint lo;
        int     pick;
        x = 0;
        y = 0;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                t = gen_newest + $urandom_range(1, 3000);
                if ($urandom_range(0, 19) == 0)
                    t = gen_newest + $urandom_range(1, 20000000);
                if (t > TIME_MAX)
                    t = TIME_MAX;
                x = rand_coord(x);
                y = rand_coord(y);
                push_add(t, x, y, rand_head());
            end else if (pick < 52) begin
                // late, equal or wild add time
                if ($urandom_range(0, 1))
                    t = gen_newest - $urandom_range(0, 500);
                else
                    t = $signed($urandom);
                push_add(t, rand_coord(0), rand_coord(0), rand_head());
            end else begin
                lo = (gen_times.size() > 0) ? gen_times[0] : 0;
                case ($urandom_range(0, 5))
                    0, 1: t = lo + $urandom_range(0, 32'(gen_newest - lo));
                    2:    t = gen_newest + $urandom_range(0, 70000);
                    3:    t = lo - $urandom_range(1, 5000);
                    4:    t = (gen_times.size() > 0) ?
                              gen_times[$urandom_range(0, gen_times.size() - 1)] : 0;
                    default: t = $signed($urandom);
                endcase
                if (t > TIME_MAX)
                    t = TIME_MAX;
                if (t < TIME_MIN)
                    t = TIME_MIN;
                push_query(t);
            end
        end
    endtask

    longint phase_horizon[5] = '{0, 65535, 1, 0, LIMIT_RESET};

    initial begin
        phase_horizon[3] = $urandom_range(0, 65535);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, single sample, early query, short-way heading,
        // extremes, late and equal adds, extrapolation at the reset horizon
        push_query(0);
        push_add(-100000, 8388607, -8388608, 23039);
        push_query(-200000);
        push_query(-100000);
        push_query(-50000);
        push_add(-100000, 1, 1, 1);
        push_add(-200000, 1, 1, 1);
        push_add(-99000, -8388608, 8388607, -23040);
        push_query(-99500);
        push_query(TIME_MIN);
        push_query(-99000);
        push_query(TIME_MAX);
        push_add(-98000, 0, 0, 32767);
        push_add(-97000, 100, -100, -32768);
        push_query(-97500);
        push_add(-96000, 8388607, -8388608, 20000);
        push_query(-96500);
        push_query(-96000);
        push_query(-95950);
        push_query(-95800);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_horizon(phase_horizon[p]);
            sender_idles   = (p % 2 == 0);
            receiver_idles = (p != 1);
            if (p == 2)
                hold_requests++;
            random_items(126);
            wait_idle();
        end

        // top of the time range
        push_add(2147483646, 5, 5, 5);
        push_add(TIME_MAX, 10, 10, 10);
        push_query(TIME_MAX);
        push_query(2147483000);
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_positions.size() > 0)
            errors++;
        $display("Sent %0d adds and %0d queries, checked %0d positions, %0d errors",
                 adds_sent, queries_sent, positions_checked, errors);
        $display("Horizons 200, 0, 65535, 1, random; ring wrapped, long output stall done");
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tpi_pkg.sv
rtl/tpi_ram.sv
rtl/tpi_muldiv.sv
rtl/timed_position_interpolator.sv
bench/testbench.sv
